// File: hw/rtl/bpa_pkg.sv
// Bitmap page allocator: shared constants, codes and sequencer types.
// No dependencies; used by bitmap_page_allocator_top and tb_top.
package bpa_pkg;

  localparam int POOL_PAGES_DEF = 4096;
  localparam int MAX_RUN_DEF    = 64;
  localparam int WORD_W         = 32;   // bitmap word stored per memory entry
  localparam int CHUNK_W        = 8;    // bits examined per scan step
  localparam int PAGE_W         = 20;
  localparam int CNT_W          = 13;
  localparam int CFG_IDX_W      = 3;

  localparam logic [1:0] OP_RUN  = 2'd0;
  localparam logic [1:0] OP_AT   = 2'd1;
  localparam logic [1:0] OP_FREE = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_VIRT = 2'd1;
  localparam logic [1:0] STAT_NO_PHYS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KPHYS_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPHYS_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KVIRT_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UVIRT_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KPAGES     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPHYS_PAGES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UVIRT_PAGES = 3'd6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOAD,
    S_WORK,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    J_RUN,
    J_MARK,
    J_FRAME,
    J_VSET,
    J_VCLR,
    J_PCLR
  } job_e;

endpackage

// File: hw/rtl/bpa_bitmap_ram.sv
// Single-port-write, single-port-read word memory holding all four bitmaps.
// Read data is registered. Depends on nothing beyond its parameters.
module bpa_bitmap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bitmap_page_allocator_top.sv
// Bitmap page allocator top level: config registers, sequencer and scan unit.
// Depends on bpa_pkg and bpa_bitmap_ram.
//
// After reset the four bitmaps are zeroed by a clearing pass over all
// 4*POOL_PAGES/32 words (512 at the default size) during which no request is
// taken; config writes are accepted throughout. Requests are handled one at a
// time. The bitmaps sit in one 32-bit-wide memory with a registered read, and
// a single scan unit walks a loaded word 8 bits per cycle, pausing while each
// new word is read through S_READ and S_LOAD. An alloc-run scans the virtual
// map up to the free run, marks it in one to three words, then takes frames
// first-fit, resuming where the previous frame was found. Alloc-at marks the
// page, then runs a first-fit frame search from the bottom of the pool, then
// gives the result. Free clears the virtual page, the frame, or both. Each
// result is held until its transfer completes.
module bitmap_page_allocator_top
  import bpa_pkg::*;
#(
  parameter int POOL_PAGES = POOL_PAGES_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAGE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic                 pool_i,
  input  logic [6:0]           page_count_i,
  input  logic [PAGE_W-1:0]    virt_page_i,
  input  logic [PAGE_W-1:0]    phys_page_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [PAGE_W-1:0]    out_virt_page_o,
  output logic [PAGE_W-1:0]    out_phys_page_o,
  output logic                 last_o
);

  localparam int LW   = $clog2(POOL_PAGES);
  localparam int OW   = $clog2(WORD_W);
  localparam int NW   = POOL_PAGES / WORD_W;
  localparam int WIW  = $clog2(NW);
  localparam int AW   = WIW + 2;
  localparam int DEPTH = 4 * NW;
  localparam int RW   = $clog2(MAX_RUN + 1);
  localparam int CW   = (LW + 1 > CNT_W) ? LW + 1 : CNT_W;
  localparam int CBW  = $clog2(CHUNK_W);

  function automatic logic [LW:0] clamp_f(input logic [CNT_W-1:0] n);
    logic [CW-1:0] e;
    e = CW'(n);
    if (e > CW'(POOL_PAGES)) begin
      return (LW+1)'(POOL_PAGES);
    end
    return (LW+1)'(e);
  endfunction

  // configuration registers
  logic [PAGE_W-1:0] kpb_q, upb_q, kvb_q, uvb_q;
  logic [CNT_W-1:0]  kpg_q, upp_q, uvp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kpb_q <= PAGE_W'(512);
      upb_q <= PAGE_W'(2560);
      kvb_q <= PAGE_W'(786688);
      uvb_q <= PAGE_W'(2048);
      kpg_q <= CNT_W'(2048);
      upp_q <= CNT_W'(2048);
      uvp_q <= CNT_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KPHYS_BASE:  kpb_q <= cfg_data_i;
        CFG_UPHYS_BASE:  upb_q <= cfg_data_i;
        CFG_KVIRT_BASE:  kvb_q <= cfg_data_i;
        CFG_UVIRT_BASE:  uvb_q <= cfg_data_i;
        CFG_KPAGES:      kpg_q <= cfg_data_i[CNT_W-1:0];
        CFG_UPHYS_PAGES: upp_q <= cfg_data_i[CNT_W-1:0];
        CFG_UVIRT_PAGES: uvp_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  job_e   job_q, job_d;
  logic              user_q, user_d, puser_q, puser_d, pin_q, pin_d, cont_q, cont_d;
  logic [LW:0]       ptr_q, ptr_d, fptr_q, fptr_d, end_q, end_d, pidx_q, pidx_d;
  logic [RW-1:0]     run_q, run_d, n_q, n_d, i_q, i_d;
  logic [PAGE_W-1:0] va_q, va_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              ov_q, ov_d, last_q, last_d;
  logic [1:0]        stat_q, stat_d;
  logic [PAGE_W-1:0] ovp_q, ovp_d, opp_q, opp_d;

  // pool-dependent selections
  logic              sel;
  logic [PAGE_W-1:0] vbase, fbase;
  logic [LW:0]       vlim, flim, plim;
  logic [PAGE_W:0]   vdiff, pdiff;
  logic              vin, pu, pin;

  assign sel   = (state_q == S_IDLE) ? pool_i : user_q;
  assign vbase = sel ? uvb_q : kvb_q;
  assign fbase = sel ? upb_q : kpb_q;
  assign vlim  = clamp_f(sel ? uvp_q : kpg_q);
  assign flim  = clamp_f(sel ? upp_q : kpg_q);
  assign vdiff = {1'b0, virt_page_i} - {1'b0, vbase};
  assign vin   = !vdiff[PAGE_W] && (vdiff[PAGE_W-1:0] < PAGE_W'(vlim));
  assign pu    = phys_page_i >= upb_q;
  assign pdiff = pu ? ({1'b0, phys_page_i} - {1'b0, upb_q})
                    : ({1'b0, phys_page_i} - {1'b0, kpb_q});
  assign plim  = clamp_f(pu ? upp_q : kpg_q);
  assign pin   = !pdiff[PAGE_W] && (pdiff[PAGE_W-1:0] < PAGE_W'(plim));

  // memory port
  logic              we, re;
  logic [1:0]        rmap;
  logic [LW:0]       rptr;
  logic [AW-1:0]     raddr, waddr;
  logic [WORD_W-1:0] wdata, rdata;

  assign rmap  = (job_q == J_FRAME) ? {1'b1, user_q} :
                 (job_q == J_PCLR)  ? {1'b1, puser_q} : {1'b0, user_q};
  assign rptr  = (job_q == J_FRAME) ? fptr_q : ptr_q;
  assign raddr = {rmap, rptr[LW-1:OW]};
  assign re    = (state_q == S_READ);
  assign waddr = (state_q == S_CLEAR) ? clr_q : raddr;

  bpa_bitmap_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // scan unit: one chunk of the loaded word per cycle
  logic              rhit, rmiss, fhit, fmiss;
  logic [RW-1:0]     rrun;
  logic [LW:0]       rstart, fb;
  logic [WORD_W-1:0] fbit, mmask, pbit;

  always_comb begin
    logic [LW:0] b;
    rhit = 1'b0; rmiss = 1'b0; rrun = run_q; rstart = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      b = ptr_q + (LW+1)'(j);
      if (!rhit && !rmiss) begin
        if (b >= vlim) begin
          rmiss = 1'b1;
        end else if (word_q[{ptr_q[OW-1:CBW], CBW'(j)}]) begin
          rrun = '0;
        end else begin
          rrun = rrun + 1'b1;
          if (rrun == n_q) begin
            rhit   = 1'b1;
            rstart = b + 1'b1 - (LW+1)'(n_q);
          end
        end
      end
    end
  end

  always_comb begin
    logic [LW:0] b;
    fhit = 1'b0; fmiss = 1'b0; fb = '0; fbit = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      b = fptr_q + (LW+1)'(j);
      if (!fhit && !fmiss) begin
        if (b >= flim) begin
          fmiss = 1'b1;
        end else if (!word_q[{fptr_q[OW-1:CBW], CBW'(j)}]) begin
          fhit = 1'b1;
          fb   = b;
          fbit = WORD_W'(1) << {fptr_q[OW-1:CBW], CBW'(j)};
        end
      end
    end
  end

  always_comb begin
    logic [LW:0] idx;
    for (int k = 0; k < WORD_W; k++) begin
      idx = ptr_q + (LW+1)'(k);
      mmask[k] = (idx >= end_q - (LW+1)'(n_q)) && (idx < end_q);
    end
  end

  assign pbit = WORD_W'(1) << ptr_q[OW-1:0];

  // sequencer
  always_comb begin
    state_d = state_q; job_d = job_q; user_d = user_q; puser_d = puser_q;
    pin_d = pin_q; cont_d = cont_q; ptr_d = ptr_q; fptr_d = fptr_q;
    end_d = end_q; pidx_d = pidx_q; run_d = run_q; n_d = n_q; i_d = i_q;
    va_d = va_q; word_d = word_q; clr_d = clr_q; ov_d = ov_q;
    last_d = last_q; stat_d = stat_q; ovp_d = ovp_q; opp_d = opp_q;
    we = 1'b0; wdata = '0;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          user_d = pool_i;
          ovp_d  = '0; opp_d = '0; last_d = 1'b1; stat_d = STAT_NO_VIRT;
          case (opcode_i)
            OP_RUN: begin
              if (page_count_i == '0 || page_count_i > 7'(MAX_RUN)) begin
                ov_d = 1'b1; cont_d = 1'b0; state_d = S_EMIT;
              end else begin
                job_d = J_RUN; ptr_d = '0; run_d = '0;
                n_d = RW'(page_count_i); state_d = S_READ;
              end
            end
            OP_AT: begin
              ovp_d = virt_page_i;
              if (!vin) begin
                ov_d = 1'b1; cont_d = 1'b0; state_d = S_EMIT;
              end else begin
                job_d = J_VSET; ptr_d = vdiff[LW:0]; n_d = RW'(1); i_d = '0;
                va_d = virt_page_i; state_d = S_READ;
              end
            end
            OP_FREE: begin
              ovp_d = virt_page_i; opp_d = phys_page_i; stat_d = STAT_OK;
              cont_d = 1'b0; pin_d = pin; puser_d = pu; pidx_d = pdiff[LW:0];
              if (vin) begin
                job_d = J_VCLR; ptr_d = vdiff[LW:0]; state_d = S_READ;
              end else if (pin) begin
                job_d = J_PCLR; ptr_d = pdiff[LW:0]; state_d = S_READ;
              end else begin
                ov_d = 1'b1; state_d = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        word_d  = rdata;
        state_d = S_WORK;
      end
      S_WORK: begin
        case (job_q)
          J_RUN: begin
            if (rmiss) begin
              ov_d = 1'b1; cont_d = 1'b0; state_d = S_EMIT;
            end else if (rhit) begin
              end_d = rstart + (LW+1)'(n_q);
              ptr_d = {rstart[LW:OW], {OW{1'b0}}};
              va_d  = vbase + PAGE_W'(rstart);
              job_d = J_MARK; state_d = S_READ;
            end else begin
              run_d = rrun;
              ptr_d = ptr_q + (LW+1)'(CHUNK_W);
              if (ptr_d[OW-1:0] == '0) begin
                state_d = S_READ;
              end
            end
          end
          J_MARK: begin
            we = 1'b1; wdata = word_q | mmask;
            if (ptr_q + (LW+1)'(WORD_W) < end_q) begin
              ptr_d = ptr_q + (LW+1)'(WORD_W);
            end else begin
              job_d = J_FRAME; fptr_d = '0; i_d = '0;
            end
            state_d = S_READ;
          end
          J_FRAME: begin
            if (fmiss) begin
              stat_d = STAT_NO_PHYS; ovp_d = va_q; opp_d = '0; last_d = 1'b1;
              ov_d = 1'b1; cont_d = 1'b0; state_d = S_EMIT;
            end else if (fhit) begin
              we = 1'b1; wdata = word_q | fbit; word_d = word_q | fbit;
              stat_d = STAT_OK; ovp_d = va_q; opp_d = fbase + PAGE_W'(fb);
              last_d = (i_q + 1'b1 == n_q); cont_d = (i_q + 1'b1 != n_q);
              i_d = i_q + 1'b1; va_d = va_q + 1'b1;
              ov_d = 1'b1; state_d = S_EMIT;
            end else begin
              fptr_d = fptr_q + (LW+1)'(CHUNK_W);
              if (fptr_d[OW-1:0] == '0) begin
                state_d = S_READ;
              end
            end
          end
          J_VSET: begin
            we = 1'b1; wdata = word_q | pbit;
            job_d = J_FRAME; fptr_d = '0; state_d = S_READ;
          end
          J_VCLR: begin
            we = 1'b1; wdata = word_q & ~pbit;
            if (pin_q) begin
              job_d = J_PCLR; ptr_d = pidx_q; state_d = S_READ;
            end else begin
              ov_d = 1'b1; state_d = S_EMIT;
            end
          end
          J_PCLR: begin
            we = 1'b1; wdata = word_q & ~pbit;
            ov_d = 1'b1; state_d = S_EMIT;
          end
          default: ;
        endcase
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          ov_d    = 1'b0;
          state_d = cont_q ? S_WORK : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      job_q   <= J_RUN;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      cont_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      cont_q  <= cont_d;
    end
  end

  always_ff @(posedge clk_i) begin
    user_q <= user_d; puser_q <= puser_d; pin_q <= pin_d;
    ptr_q <= ptr_d; fptr_q <= fptr_d; end_q <= end_d; pidx_q <= pidx_d;
    run_q <= run_d; n_q <= n_d; i_q <= i_d; va_q <= va_d; word_q <= word_d;
    last_q <= last_d; stat_q <= stat_d; ovp_q <= ovp_d; opp_q <= opp_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = ov_q;
  assign status_o        = stat_q;
  assign out_virt_page_o = ovp_q;
  assign out_phys_page_o = opp_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  a_valid_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_EMIT)
    else $error("result valid outside emit state");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !out_valid_o)
    else $error("request taken while a result is pending");
  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (last_o && out_phys_page_o == '0))
    else $error("failure result not final or carries a frame");
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WORK && job_q == J_FRAME) |-> i_q < n_q)
    else $error("frame taken beyond the requested run");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for bitmap_page_allocator_top: directed table, then random phases.
// Depends on bpa_pkg and the RTL of the block; holds its own allocator predictor.
module tb_top;
  import bpa_pkg::*;

  typedef struct {
    logic [1:0]        op;
    logic              pool;
    logic [6:0]        count;
    logic [PAGE_W-1:0] virt;
    logic [PAGE_W-1:0] phys;
    bit                fixed;   // expectation typed in below, not predicted
    int                n_exp;
    logic [1:0]        e_stat;
    logic [PAGE_W-1:0] e_virt;
    logic [PAGE_W-1:0] e_phys;
  } req_t;

  typedef struct {
    logic [1:0]        status;
    logic [PAGE_W-1:0] virt;
    logic [PAGE_W-1:0] phys;
    logic              is_last;
  } mapping_t;

  typedef struct {
    bit                pool;
    logic [PAGE_W-1:0] virt;
    logic [PAGE_W-1:0] phys;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAGE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode = OP_RUN;
  logic pool = 1'b0;
  logic [6:0] page_count = '0;
  logic [PAGE_W-1:0] virt_page = '0;
  logic [PAGE_W-1:0] phys_page = '0;
  logic out_valid_o;
  logic out_stall = 1'b1;
  logic [1:0] status_o;
  logic [PAGE_W-1:0] out_virt_page_o, out_phys_page_o;
  logic last_o;
  req_t cur_req;
  bit quiet = 1'b0;

  // predictor state
  bit frame_map [2][POOL_PAGES_DEF];
  bit virt_map [2][POOL_PAGES_DEF];
  logic [PAGE_W-1:0] phys_base [2];
  logic [PAGE_W-1:0] virt_base [2];
  logic [CNT_W-1:0] kern_pages, user_phys_pages, user_virt_pages;

  mapping_t pending_maps[$];
  grant_t granted[$];
  int mismatches = 0;

  bitmap_page_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .opcode_i(opcode), .pool_i(pool), .page_count_i(page_count),
    .virt_page_i(virt_page), .phys_page_i(phys_page),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .status_o(status_o), .out_virt_page_o(out_virt_page_o),
    .out_phys_page_o(out_phys_page_o), .last_o(last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int clamp_pages(logic [CNT_W-1:0] n);
    return (n > POOL_PAGES_DEF) ? POOL_PAGES_DEF : int'(n);
  endfunction

  function automatic void push_map(logic [1:0] st, logic [PAGE_W-1:0] v,
                                   logic [PAGE_W-1:0] p, logic l);
    mapping_t m;
    m.status = st;
    m.virt = v;
    m.phys = p;
    m.is_last = l;
    pending_maps.push_back(m);
  endfunction

  // first-fit frame; -1 when the pool is full
  function automatic int take_frame(bit pl, int lim);
    for (int i = 0; i < lim; i++) begin
      if (!frame_map[pl][i]) begin
        frame_map[pl][i] = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void model_request(req_t r);
    int vlim, flim, start, run, fr;
    logic [PAGE_W-1:0] vb, fb, va;
    logic [31:0] idx;
    grant_t g;
    vlim = clamp_pages(r.pool ? user_virt_pages : kern_pages);
    flim = clamp_pages(r.pool ? user_phys_pages : kern_pages);
    vb = virt_base[r.pool];
    fb = phys_base[r.pool];
    g.pool = r.pool;
    case (r.op)
      OP_RUN: begin
        start = -1;
        run = 0;
        if (r.count != 0 && r.count <= MAX_RUN_DEF) begin
          for (int i = 0; i < vlim; i++) begin
            if (virt_map[r.pool][i]) run = 0;
            else begin
              run++;
              if (run == r.count) begin
                start = i + 1 - r.count;
                break;
              end
            end
          end
        end
        if (start < 0) push_map(STAT_NO_VIRT, '0, '0, 1'b1);
        else begin
          for (int i = 0; i < r.count; i++) virt_map[r.pool][start + i] = 1'b1;
          for (int i = 0; i < r.count; i++) begin
            va = vb + PAGE_W'(start + i);
            fr = take_frame(r.pool, flim);
            if (fr < 0) begin
              push_map(STAT_NO_PHYS, va, '0, 1'b1);
              return;
            end
            g.virt = va;
            g.phys = fb + PAGE_W'(fr);
            granted.push_back(g);
            push_map(STAT_OK, va, g.phys, (i + 1) == r.count);
          end
        end
      end
      OP_AT: begin
        idx = {12'b0, r.virt} - {12'b0, vb};
        if (idx >= vlim) push_map(STAT_NO_VIRT, r.virt, '0, 1'b1);
        else begin
          virt_map[r.pool][idx] = 1'b1;
          fr = take_frame(r.pool, flim);
          if (fr < 0) push_map(STAT_NO_PHYS, r.virt, '0, 1'b1);
          else begin
            g.virt = r.virt;
            g.phys = fb + PAGE_W'(fr);
            granted.push_back(g);
            push_map(STAT_OK, r.virt, g.phys, 1'b1);
          end
        end
      end
      OP_FREE: begin
        idx = {12'b0, r.virt} - {12'b0, vb};
        if (idx < vlim) virt_map[r.pool][idx] = 1'b0;
        // frame pool chosen by the user base, whatever the pool field says
        if (r.phys >= phys_base[1]) begin
          idx = {12'b0, r.phys} - {12'b0, phys_base[1]};
          if (idx < clamp_pages(user_phys_pages)) frame_map[1][idx] = 1'b0;
        end else begin
          idx = {12'b0, r.phys} - {12'b0, phys_base[0]};
          if (idx < clamp_pages(kern_pages)) frame_map[0][idx] = 1'b0;
        end
        push_map(STAT_OK, r.virt, r.phys, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // request transfer: predict, or take the typed expectation
  always @(posedge clk_i) begin
    int before_n;
    if (in_valid && !in_stall_o) begin
      before_n = pending_maps.size();
      model_request(cur_req);
      if (cur_req.fixed) begin
        while (pending_maps.size() > before_n) void'(pending_maps.pop_back());
        if (cur_req.n_exp != 0)
          push_map(cur_req.e_stat, cur_req.e_virt, cur_req.e_phys, 1'b1);
      end
    end
  end

  // result transfer
  always @(posedge clk_i) begin
    mapping_t m;
    if (out_valid_o && !out_stall) begin
      if (pending_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d v=%h p=%h last=%b",
                   status_o, out_virt_page_o, out_phys_page_o, last_o);
      end else begin
        m = pending_maps.pop_front();
        if (m.status !== status_o || m.virt !== out_virt_page_o ||
            m.phys !== out_phys_page_o || m.is_last !== last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d v=%h p=%h last=%b, got st=%0d v=%h p=%h last=%b",
                     m.status, m.virt, m.phys, m.is_last,
                     status_o, out_virt_page_o, out_phys_page_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 11);

  // leaves the write enable high; the caller drops it after the last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_KPHYS_BASE:  phys_base[0] = val;
      CFG_UPHYS_BASE:  phys_base[1] = val;
      CFG_KVIRT_BASE:  virt_base[0] = val;
      CFG_UVIRT_BASE:  virt_base[1] = val;
      CFG_KPAGES:      kern_pages = val[CNT_W-1:0];
      CFG_UPHYS_PAGES: user_phys_pages = val[CNT_W-1:0];
      CFG_UVIRT_PAGES: user_virt_pages = val[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_phase(logic [PAGE_W-1:0] kpb, upb, kvb, uvb, kp, upp, uvp);
    cfg_write(CFG_KPHYS_BASE, kpb);
    cfg_write(CFG_UPHYS_BASE, upb);
    cfg_write(CFG_KVIRT_BASE, kvb);
    cfg_write(CFG_UVIRT_BASE, uvb);
    cfg_write(CFG_KPAGES, kp);
    cfg_write(CFG_UPHYS_PAGES, upp);
    cfg_write(CFG_UVIRT_PAGES, uvp);
    cfg_we <= 1'b0;
  endtask

  // called on a rising edge; returns on the edge of the transfer
  task automatic send(req_t r);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 60);
    end
    in_valid <= 1'b1;
    cur_req <= r;
    opcode <= r.op;
    pool <= r.pool;
    page_count <= r.count;
    virt_page <= r.virt;
    phys_page <= r.phys;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  function automatic req_t mk(logic [1:0] op, logic pl, logic [6:0] cnt,
                              logic [PAGE_W-1:0] v, logic [PAGE_W-1:0] p);
    req_t r;
    r.op = op;
    r.pool = pl;
    r.count = cnt;
    r.virt = v;
    r.phys = p;
    r.fixed = 1'b0;
    r.n_exp = 0;
    r.e_stat = STAT_OK;
    r.e_virt = '0;
    r.e_phys = '0;
    return r;
  endfunction

  function automatic req_t mkx(req_t r, int n, logic [1:0] st,
                               logic [PAGE_W-1:0] v, logic [PAGE_W-1:0] p);
    r.fixed = 1'b1;
    r.n_exp = n;
    r.e_stat = st;
    r.e_virt = v;
    r.e_phys = p;
    return r;
  endfunction

  // mostly sensible requests, some noise
  function automatic req_t random_request();
    req_t r;
    int k, lim, sel;
    grant_t g;
    r = mk(OP_RUN, 1'($urandom_range(1)), 7'($urandom_range(1, 8)),
           20'($urandom), 20'($urandom));
    k = $urandom_range(99);
    lim = clamp_pages(r.pool ? user_virt_pages : kern_pages);
    if (k < 20) r.count = 7'($urandom_range(1, 64));
    else if (k < 24) r.count = 7'($urandom_range(0, 127));
    else if (k < 36) r.op = OP_RUN;
    else if (k < 56) begin
      r.op = OP_AT;
      if (lim > 0) r.virt = virt_base[r.pool] + PAGE_W'($urandom_range(lim - 1));
    end else if (k < 62) r.op = OP_AT;
    else if (k < 88 && granted.size() > 0) begin
      sel = $urandom_range(granted.size() - 1);
      g = granted[sel];
      granted.delete(sel);
      r.op = OP_FREE;
      r.pool = g.pool;
      r.virt = g.virt;
      r.phys = g.phys;
    end else if (k < 95) r.op = OP_FREE;
    else r.op = 2'd3;
    return r;
  endfunction

  initial begin
    req_t dir [$];
    kern_pages = 13'd2048;
    user_phys_pages = 13'd2048;
    user_virt_pages = 13'd4096;
    phys_base[0] = 20'd512;
    phys_base[1] = 20'd2560;
    virt_base[0] = 20'd786688;
    virt_base[1] = 20'd2048;

    dir.push_back(mkx(mk(OP_RUN, 0, 1, 0, 0), 1, STAT_OK, 20'd786688, 20'd512));
    dir.push_back(mkx(mk(OP_RUN, 0, 0, 0, 0), 1, STAT_NO_VIRT, 0, 0));
    dir.push_back(mkx(mk(OP_RUN, 0, 65, 0, 0), 1, STAT_NO_VIRT, 0, 0));
    dir.push_back(mkx(mk(OP_RUN, 1, 127, 20'hFFFFF, 20'hFFFFF), 1, STAT_NO_VIRT, 0, 0));
    dir.push_back(mk(OP_RUN, 0, 64, 0, 0));
    dir.push_back(mk(OP_RUN, 1, 64, 0, 0));
    dir.push_back(mkx(mk(OP_AT, 1, 1, 0, 0), 1, STAT_NO_VIRT, 0, 0));
    dir.push_back(mkx(mk(OP_AT, 1, 1, 20'hFFFFF, 0), 1, STAT_NO_VIRT, 20'hFFFFF, 0));
    dir.push_back(mk(OP_AT, 0, 1, 20'd786788, 0));
    dir.push_back(mk(OP_AT, 0, 1, 20'd786688, 0));   // already marked page
    dir.push_back(mk(OP_AT, 0, 1, 20'd788735, 0));   // top of kernel range
    dir.push_back(mkx(mk(OP_AT, 0, 1, 20'd788736, 0), 1, STAT_NO_VIRT, 20'd788736, 0));
    dir.push_back(mkx(mk(OP_FREE, 0, 1, 20'd786688, 20'd512), 1, STAT_OK,
                      20'd786688, 20'd512));
    dir.push_back(mkx(mk(OP_FREE, 1, 1, 0, 20'hFFFFF), 1, STAT_OK, 0, 20'hFFFFF));
    dir.push_back(mkx(mk(OP_FREE, 0, 1, 0, 0), 1, STAT_OK, 0, 0));
    dir.push_back(mk(OP_FREE, 1, 1, 20'd2048, 20'd2560));
    dir.push_back(mkx(mk(2'd3, 1, 127, 20'hFFFFF, 20'hFFFFF), 0, STAT_OK, 0, 0));
    dir.push_back(mk(OP_RUN, 1, 2, 0, 0));
    dir.push_back(mk(OP_RUN, 0, 3, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir[i]) send(dir[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_phase(20'd512, 20'd2560, 20'd786688, 20'd2048, 20'd64, 20'd16, 20'd128);
        1: set_phase(20'hFFFF0, 20'hFFFFF, 20'hFFFE0, 20'hFFFFF, 20'd0, 20'd8191, 20'd4096);
        2: set_phase(20'd0, 20'd40, 20'd0, 20'd0, 20'd4096, 20'd40, 20'd8191);
        3: set_phase(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                     20'($urandom_range(8, 300)), 20'($urandom_range(8, 300)),
                     20'($urandom_range(8, 300)));
        default: set_phase(20'd100, 20'd5000, 20'd7000, 20'd9000, 20'd200, 20'd24, 20'd48);
      endcase
      quiet = (ph == 2);
      repeat (20) send(random_request());
      drain();
    end

    if (mismatches == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
